/* sv/qesm_pkg.sv */
// Shared types and constants for the quadrature encoder speed meter.
// No dependencies; imported by every module of the block.
package qesm_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_SLOTS_PER_REV = 2'd0;
	localparam logic [1:0] CFG_WINDOW_MS     = 2'd1;
	localparam logic [1:0] CFG_GEAR_RATIO    = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int SLOTS_W  = 11;
	localparam int WINDOW_W = 10;
	localparam int GEAR_W   = 8;

	localparam logic [SLOTS_W-1:0]  SLOTS_RESET  = 11'd1;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 10'd10;
	localparam logic [GEAR_W-1:0]   GEAR_RESET   = 8'd1;

	localparam int CNT_W    = 16;
	localparam int CH_MAX_W = 3;

	// pulse * 60000 stays below 2^31; slots * 2 * window * gear below 2^30
	localparam int DVD_W = 31;
	localparam int DVS_W = 30;

	localparam logic [15:0] RPM_SCALE = 16'd60000;

	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic operation;
		logic channel;
		logic plus_level;
		logic minus_level;
	} qesm_in_t;

	typedef struct packed {
		logic                    channel_out;
		logic signed [CNT_W-1:0] pulse_count;
		logic signed [CNT_W-1:0] speed_rpm;
		logic                    saturated;
		logic                    last;
	} qesm_out_t;

	// one encoder edge toward the counter bank
	typedef struct packed {
		logic                valid;
		logic [CH_MAX_W-1:0] channel;
		logic                up;
	} qesm_edge_t;

endpackage

/* sv/qesm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on qesm_pkg for operand widths.
module qesm_div
	import qesm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]    rem_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;

	logic [DVD_W:0]   shifted;
	logic [DVD_W+1:0] diff;
	logic             borrow;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - (DVD_W+2)'(dvs_q);
	assign borrow  = diff[DVD_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// keep the partial remainder when the trial subtract borrows
			rem_q <= borrow ? shifted[DVD_W-1:0] : diff[DVD_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ~borrow};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* sv/qesm_cnt.sv */
// Per-channel saturating pulse counters with clip flags.
// Depends on qesm_pkg for the edge struct and count limits.
module qesm_cnt
	import qesm_pkg::*;
#(
	parameter int CHANNELS = 2,
	parameter int CH_W     = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  qesm_edge_t              edge_evt,
	input  logic [CH_W-1:0]         rd_idx,
	input  logic                    rd_clr,
	output logic signed [CNT_W-1:0] rd_pulse,
	output logic                    rd_clip
);

	logic signed [CNT_W-1:0] acc_q  [CHANNELS];
	logic                    clip_q [CHANNELS];

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic hit;
		logic clr;

		// an edge on a channel with no lane matches nothing and is dropped
		assign hit = edge_evt.valid && (edge_evt.channel == CH_MAX_W'(i));
		assign clr = rd_clr && (rd_idx == CH_W'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[i]  <= '0;
				clip_q[i] <= 1'b0;
			end else if (clr) begin
				acc_q[i]  <= '0;
				clip_q[i] <= 1'b0;
			end else if (hit) begin
				if (edge_evt.up) begin
					if (acc_q[i] == CNT_MAX) begin
						clip_q[i] <= 1'b1;
					end else begin
						acc_q[i] <= acc_q[i] + 16'sd1;
					end
				end else begin
					if (acc_q[i] == CNT_MIN) begin
						clip_q[i] <= 1'b1;
					end else begin
						acc_q[i] <= acc_q[i] - 16'sd1;
					end
				end
			end
		end
	end

	assign rd_pulse = acc_q[rd_idx];
	assign rd_clip  = clip_q[rd_idx];

endmodule

/* sv/quadrature_encoder_speed_meter.sv */
// Quadrature encoder speed meter: top level with sequencer and output register.
// Depends on qesm_pkg, qesm_cnt and qesm_div.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): an edge transaction updates one
//   channel's saturating pulse count; a tick transaction emits one result per
//   channel, in channel order, and clears every count.
//   out channel (out_valid/out_ready/out_data): one result per channel, last
//   set on the final one. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
//   is always ready; an unknown index is ignored. Zero registers act as one.
//   Edge transactions are taken back to back while no tick runs. A tick forms
//   the divisor (S_MUL1, S_MUL2), then per channel loads the count (S_LOAD),
//   starts the divider (S_START), waits for it at one quotient bit per cycle
//   in the shared divider (S_WAIT) and moves the result into the output
//   register (S_OUT), where it holds while the receiver stalls. in_ready is
//   low for the whole tick. A stalled output holds its result; the sequencer
//   waits for the output register to drain, and the next transaction is taken
//   as soon as the last result sits in that register.
//   Reset: counts and clip flags clear, registers take slots 1, window 10,
//   gear 1, out_valid drops.
module quadrature_encoder_speed_meter
	import qesm_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qesm_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qesm_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_LOAD,
		S_START,
		S_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic [SLOTS_W-1:0]  slots_q;
	logic [WINDOW_W-1:0] window_q;
	logic [GEAR_W-1:0]   gear_q;

	logic [SLOTS_W-1:0]  slots_eff;
	logic [WINDOW_W-1:0] window_eff;
	logic [GEAR_W-1:0]   gear_eff;

	logic [20:0]      prod1_q;
	logic [28:0]      prod2;
	logic [DVS_W-1:0] divisor_q;
	logic [DVD_W-1:0] dvd_q;

	logic [CH_W-1:0]         ch_q;
	logic signed [CNT_W-1:0] pulse_q;
	logic                    clip_q;
	logic                    neg_q;

	logic signed [CNT_W-1:0] rd_pulse;
	logic                    rd_clip;
	logic [16:0]             mag;
	logic [DVD_W-1:0]        dvd_d;

	logic             div_start;
	logic             div_busy;
	logic [DVD_W-1:0] quotient;

	logic             out_valid_q;
	qesm_out_t        out_q;
	logic             out_load;
	logic             rpm_sat;
	logic [CNT_W-1:0] rpm;

	qesm_edge_t edge_evt;
	logic       in_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;

	assign edge_evt.valid   = in_fire && (in_data.operation == OP_EDGE);
	assign edge_evt.channel = CH_MAX_W'(in_data.channel);
	assign edge_evt.up      = in_data.plus_level ^ in_data.minus_level;

	assign slots_eff  = (slots_q == '0) ? SLOTS_W'(1) : slots_q;
	assign window_eff = (window_q == '0) ? WINDOW_W'(1) : window_q;
	assign gear_eff   = (gear_q == '0) ? GEAR_W'(1) : gear_q;
	assign prod2      = 29'(prod1_q) * 29'(gear_eff);

	// magnitude of the count, -32768 gives 32768
	assign mag   = rd_pulse[CNT_W-1] ? (17'd0 - {rd_pulse[CNT_W-1], rd_pulse})
	                                 : {1'b0, rd_pulse};
	assign dvd_d = DVD_W'(33'(mag) * 33'(RPM_SCALE));

	assign div_start = (state_q == S_START);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		if (neg_q) begin
			rpm_sat = (quotient > DVD_W'(32768));
			rpm     = rpm_sat ? CNT_MIN : CNT_W'(17'd0 - quotient[16:0]);
		end else begin
			rpm_sat = (quotient > DVD_W'(32767));
			rpm     = rpm_sat ? CNT_MAX : quotient[CNT_W-1:0];
		end
	end

	qesm_cnt #(
		.CHANNELS (CHANNELS),
		.CH_W     (CH_W)
	) u_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.edge_evt (edge_evt),
		.rd_idx   (ch_q),
		.rd_clr   (state_q == S_LOAD),
		.rd_pulse (rd_pulse),
		.rd_clip  (rd_clip)
	);

	qesm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (divisor_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= SLOTS_RESET;
			window_q <= WINDOW_RESET;
			gear_q   <= GEAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLOTS_PER_REV: slots_q  <= cfg_data[SLOTS_W-1:0];
				CFG_WINDOW_MS:     window_q <= cfg_data[WINDOW_W-1:0];
				CFG_GEAR_RATIO:    gear_q   <= cfg_data[GEAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && in_data.operation == OP_TICK) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					ch_q    <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!div_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_MUL1) begin
			prod1_q <= 21'(slots_eff) * 21'(window_eff);
		end
		if (state_q == S_MUL2) begin
			divisor_q <= {prod2, 1'b0};
		end
		if (state_q == S_LOAD) begin
			pulse_q <= rd_pulse;
			clip_q  <= rd_clip;
			neg_q   <= rd_pulse[CNT_W-1];
			dvd_q   <= dvd_d;
		end
		if (out_load) begin
			out_q.channel_out <= ch_q[0];
			out_q.pulse_count <= pulse_q;
			out_q.speed_rpm   <= rpm;
			out_q.saturated   <= clip_q || rpm_sat;
			out_q.last        <= (ch_q == CH_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_WAIT)
		else $error("divider busy outside the wait state");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |-> divisor_q != '0)
		else $error("zero divisor at divide start");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ch_q == CH_LAST) |=> state_q == S_IDLE && out_valid_q && out_q.last)
		else $error("final result did not end the tick");

	a_no_input_during_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT || state_q == S_LOAD) |-> !edge_evt.valid)
		else $error("edge transaction taken during a tick");

endmodule
